// ===== rtl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, constants and helper functions of the JSON string escape
// encoder.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Input item and result item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } jse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
  } jse_out_t;

  // Work handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,  // one byte as it is
    CMD_ESC  = 2'd1,  // backslash and one character
    CMD_U16  = 2'd2,  // \u escape of a 16-bit value
    CMD_CODE = 2'd3   // a decoded code point
  } jse_kind_t;

  typedef struct packed {
    jse_kind_t   kind;
    logic [20:0] code;
    logic        str_end;
  } jse_cmd_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [3:0] DFA_ACCEPT = 4'd0;
  localparam logic [3:0] DFA_REJECT = 4'd1;
  localparam logic [3:0] DFA_STATES = 4'd9;

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_U      = 8'h75;

  // Configuration register index.
  localparam logic REG_ASCII_MODE = 1'b0;

  localparam logic [3:0] NEXT_STATE [0:8][0:11] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  // Lowercase hex digit.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'd0, n};
    else           r = 8'h57 + {4'd0, n};
    return r;
  endfunction

  // Byte at position pos (0..5) of the escape \uXXXX of v.
  function automatic logic [7:0] u16_char(input logic [15:0] v, input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = CH_BSLASH;
      3'd1:    r = CH_U;
      3'd2:    r = hex_char(v[15:12]);
      3'd3:    r = hex_char(v[11:8]);
      3'd4:    r = hex_char(v[7:4]);
      default: r = hex_char(v[3:0]);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/json_string_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// json_string_escape_encoder
// Turns a UTF-8 byte stream into JSON-escaped string text.
// ----------------------------------------------------------------------------
// The encoder accepts one input byte per cycle while full is low. The front
// part decodes UTF-8 and classifies each byte in the cycle it is accepted and
// writes one command into a four-entry queue; the back part turns a command
// into its output bytes at one byte per cycle through the output register,
// while that register is empty or being popped. An item produces 0 to 12
// output bytes; a byte that only continues an open sequence writes no
// command at all. Input only stalls while the queue is full behind a long
// escape or a stalled consumer. The first result of an item passes through
// the command queue and then the output register before it reaches the
// output ports. Register ascii_mode lies at byte address 0 and is to be
// written only while the block is idle; the block itself does not enforce it.
module json_string_escape_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  jse_pkg::jse_in_t  in_data,
  output logic              empty,
  input  logic              pop,
  output jse_pkg::jse_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic              ascii_mode_r;
  logic              accept;
  logic              cmd_push;
  jse_pkg::jse_cmd_t cmd;
  jse_pkg::jse_cmd_t head;
  logic              head_valid;
  logic              head_pop;
  logic              q_full;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == jse_pkg::REG_ASCII_MODE) ? {31'd0, ascii_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascii_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == jse_pkg::REG_ASCII_MODE) begin
      ascii_mode_r <= pwdata[0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  jse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  jse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_push),
    .wr_cmd   (cmd),
    .q_full   (q_full),
    .rd_en    (head_pop),
    .rd_cmd   (head),
    .rd_valid (head_valid)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ascii_mode (ascii_mode_r),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_data   (out_data),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ===== rtl/jse_front.sv =====
// ----------------------------------------------------------------------------
// jse_front
// Accepts input bytes, runs the UTF-8 decoder state and classifies each byte
// into at most one command for the back part.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  jse_pkg::jse_in_t in_item,
  output logic             cmd_push,
  output jse_pkg::jse_cmd_t cmd
);

  logic [3:0]  dfa_state_r, dfa_state_nxt;
  logic [20:0] partial_r, partial_nxt;

  logic [7:0]  b;
  logic        str_end;
  logic [3:0]  cls;
  logic [3:0]  ns;
  logic [7:0]  lead_mask;
  logic [20:0] pc_new;
  logic [7:0]  esc;

  assign b       = in_item.in_byte;
  assign str_end = in_item.string_end;
  assign cls     = jse_pkg::byte_class(b);
  assign lead_mask = 8'hFF >> cls;

  always_comb begin
    if (dfa_state_r == jse_pkg::DFA_ACCEPT) pc_new = {13'd0, lead_mask & b};
    else                                   pc_new = {partial_r[14:0], b[5:0]};
    if (dfa_state_r < jse_pkg::DFA_STATES) ns = jse_pkg::NEXT_STATE[dfa_state_r][cls];
    else                                   ns = jse_pkg::DFA_REJECT;
  end

  always_comb begin
    unique case (b)
      jse_pkg::CH_QUOTE:  esc = jse_pkg::CH_QUOTE;
      jse_pkg::CH_BSLASH: esc = jse_pkg::CH_BSLASH;
      8'h0C:              esc = 8'h66;
      8'h0A:              esc = 8'h6E;
      8'h0D:              esc = 8'h72;
      8'h09:              esc = 8'h74;
      default:            esc = 8'h00;
    endcase
  end

  always_comb begin
    dfa_state_nxt = dfa_state_r;
    partial_nxt   = partial_r;
    cmd_push      = 1'b0;
    cmd.kind      = jse_pkg::CMD_BYTE;
    cmd.code      = {13'd0, b};
    cmd.str_end   = str_end;
    if (accept) begin
      cmd_push = 1'b1;
      if (dfa_state_r != jse_pkg::DFA_ACCEPT || b[7]) begin
        cmd.kind = jse_pkg::CMD_CODE;
        if (ns == jse_pkg::DFA_ACCEPT) begin
          cmd.code      = pc_new;
          dfa_state_nxt = ns;
          partial_nxt   = pc_new;
        end else if (ns == jse_pkg::DFA_REJECT || str_end) begin
          cmd.code      = jse_pkg::REPLACEMENT;
          dfa_state_nxt = jse_pkg::DFA_ACCEPT;
          partial_nxt   = '0;
        end else begin
          // Sequence still open: nothing to emit yet.
          cmd_push      = 1'b0;
          dfa_state_nxt = ns;
          partial_nxt   = pc_new;
        end
      end else if (b >= 8'h20 && b != jse_pkg::CH_QUOTE && b != jse_pkg::CH_BSLASH) begin
        cmd.kind = jse_pkg::CMD_BYTE;
      end else if (esc != 8'h00) begin
        cmd.kind = jse_pkg::CMD_ESC;
        cmd.code = {13'd0, esc};
      end else begin
        cmd.kind = jse_pkg::CMD_U16;
      end
      if (str_end) begin
        dfa_state_nxt = jse_pkg::DFA_ACCEPT;
        partial_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfa_state_r <= jse_pkg::DFA_ACCEPT;
      partial_r   <= '0;
    end else begin
      dfa_state_r <= dfa_state_nxt;
      partial_r   <= partial_nxt;
    end
  end

endmodule

// ===== rtl/jse_queue.sv =====
// ----------------------------------------------------------------------------
// jse_queue
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module jse_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  jse_pkg::jse_cmd_t wr_cmd,
  output logic              q_full,
  input  logic              rd_en,
  output jse_pkg::jse_cmd_t rd_cmd,
  output logic              rd_valid
);

  jse_pkg::jse_cmd_t            entry_r [jse_pkg::QDEPTH];
  logic [jse_pkg::QAW-1:0]      wptr_r, rptr_r;
  logic [jse_pkg::QAW:0]        count_r;

  assign q_full   = (count_r == (jse_pkg::QAW+1)'(jse_pkg::QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) entry_r[wptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + 1'b1;
      if (rd_en) rptr_r <= rptr_r + 1'b1;
      if (wr_en && !rd_en)      count_r <= count_r + 1'b1;
      else if (!wr_en && rd_en) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/jse_back.sv =====
// ----------------------------------------------------------------------------
// jse_back
// Expands each command into its output bytes, one per cycle into an output
// register while that register is empty or being popped.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ascii_mode,
  input  jse_pkg::jse_cmd_t head,
  input  logic              head_valid,
  output logic              head_pop,
  output jse_pkg::jse_out_t out_data,
  output logic              empty,
  input  logic              pop
);

  jse_pkg::jse_out_t out_r;
  logic              out_valid_r;
  logic [3:0]        idx_r;

  logic [3:0]  len;
  logic [7:0]  byte_now;
  logic        load;
  logic        last;
  logic [20:0] c;
  logic [20:0] d;
  logic        big;
  logic [15:0] v;
  logic [3:0]  pos;

  assign c   = head.code;
  assign big = (c >= 21'h010000);
  assign d   = c - 21'h010000;

  always_comb begin
    len = 4'd1;
    case (head.kind)
      jse_pkg::CMD_BYTE: len = 4'd1;
      jse_pkg::CMD_ESC:  len = 4'd2;
      jse_pkg::CMD_U16:  len = 4'd6;
      default: begin
        if (ascii_mode)          len = big ? 4'd12 : 4'd6;
        else if (c < 21'h000080) len = 4'd1;
        else if (c < 21'h000800) len = 4'd2;
        else if (!big)           len = 4'd3;
        else                     len = 4'd4;
      end
    endcase
  end

  // Escape value and position for the \u forms; the low surrogate starts at byte six.
  always_comb begin
    if (head.kind == jse_pkg::CMD_CODE && big) begin
      if (idx_r < 4'd6) v = 16'hD800 | {6'd0, d[19:10]};
      else              v = 16'hDC00 | {6'd0, d[9:0]};
    end else begin
      v = c[15:0];
    end
    pos = (idx_r < 4'd6) ? idx_r : idx_r - 4'd6;
  end

  always_comb begin
    byte_now = c[7:0];
    case (head.kind)
      jse_pkg::CMD_BYTE: byte_now = c[7:0];
      jse_pkg::CMD_ESC:  byte_now = (idx_r == 4'd0) ? jse_pkg::CH_BSLASH : c[7:0];
      jse_pkg::CMD_U16:  byte_now = jse_pkg::u16_char(v, pos[2:0]);
      default: begin
        if (ascii_mode) begin
          byte_now = jse_pkg::u16_char(v, pos[2:0]);
        end else if (len == 4'd1) begin
          byte_now = {1'b0, c[6:0]};
        end else if (idx_r == 4'd0) begin
          case (len)
            4'd2:    byte_now = {3'b110, c[10:6]};
            4'd3:    byte_now = {4'b1110, c[15:12]};
            default: byte_now = {5'b11110, c[20:18]};
          endcase
        end else if (idx_r == len - 4'd1) begin
          byte_now = {2'b10, c[5:0]};
        end else if (idx_r == len - 4'd2) begin
          byte_now = {2'b10, c[11:6]};
        end else begin
          byte_now = {2'b10, c[17:12]};
        end
      end
    endcase
  end

  assign load     = head_valid && (!out_valid_r || pop);
  assign last     = (idx_r == len - 4'd1);
  assign head_pop = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_byte    <= byte_now;
      out_r.run_last    <= last;
      out_r.string_last <= last && head.str_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? 4'd0 : idx_r + 4'd1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_data = out_r;
  assign empty    = !out_valid_r;

endmodule
